// File: rtl/core/assert_macros.svh
// assertion macros included by beat_clock_generator_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BCG_ASSERT_NOW(lbl, ante, cons, msg)

`define BCG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/bcg_pkg.sv
// shared constants, types and codes of the beat clock generator
`timescale 1ns / 1ps

package bcg_pkg;

  localparam int TIME_BITS     = 20;
  localparam int PROGRESS_BITS = 16;
  localparam int MAX_BEATS     = 16;
  localparam int MAX_MEASURES  = 256;

  localparam int PERIOD_W = TIME_BITS;
  localparam int ACC_W    = TIME_BITS + 1;
  localparam int BEATS_W  = 5;
  localparam int MEAS_W   = 9;
  localparam int SIXT_W   = 7;
  localparam int EIGHTH_W = 6;
  localparam int POS_W    = 8;
  localparam int INDEX_W  = 7;

  localparam int MUL_A_W   = TIME_BITS + BEATS_W + 2;
  localparam int MUL_B_W   = MEAS_W;
  localparam int NUM_W     = MUL_A_W + MUL_B_W;
  localparam int DIV_CNT_W = $clog2(PROGRESS_BITS);
  localparam int MOD_CNT_W = $clog2(MEAS_W);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(125000);
  localparam logic [BEATS_W-1:0]  BEATS_RESET  = BEATS_W'(4);
  localparam logic [MEAS_W-1:0]   MEAS_RESET   = MEAS_W'(4);

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BEATS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURES = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    EV_SIXTEENTH = 2'd0,
    EV_EIGHTH    = 2'd1,
    EV_QUARTER   = 2'd2,
    EV_NONE      = 2'd3
  } bcg_event_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [BEATS_W-1:0]  beats;
    logic [MEAS_W-1:0]   measures;
    logic [SIXT_W-1:0]   sixteenth;
    logic [ACC_W-1:0]    acc;
    logic [POS_W-1:0]    measure;
  } bcg_operands_t;

  typedef struct packed {
    logic                     done;
    logic [PROGRESS_BITS-1:0] progress;
  } bcg_status_t;

endpackage

// File: rtl/core/beat_clock_generator_core.sv
// beat clock generator top level: counters, measure wrap, event list and output stage
//
//  channel  | dir | handshake                 | payload
//  s_*      | in  | s_tvalid / s_tready       | tuser kind, tdata delta
//  m_*      | out | m_tvalid / m_tready       | tuser event kind, tdata fields, tlast
//  cfg_*    | in  | cfg_wen                   | cfg_addr register, cfg_wdata value
//
// one item at a time: the accept cycle, one counter step for an advance, a serial
// modulo on a measure wrap, the progress unit (start, 4 multiplies, compare, 16 divide
// steps), the hand-over of the fraction, then 1 to 3 results, each held until taken
// the divide steps are skipped when the fraction saturates
// rst is synchronous; registers return to 125000, 4, 4 and playback stops.
// s_tready is low from acceptance until the last result is taken.
`timescale 1ns / 1ps

module beat_clock_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bcg_pkg::IN_DATA_W-1:0]    s_tdata,   // delta[19:0], zero[23:20]
  input  logic [0:0]                       s_tuser,   // kind[0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bcg_pkg::OUT_DATA_W-1:0]   m_tdata,   // event_index[6:0], measure_index[14:7], progress[30:15], running[31]
  output logic [1:0]                       m_tuser,   // event_kind[1:0]
  output logic                             m_tlast,
  input  logic                             cfg_wen,
  input  logic [bcg_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [bcg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WRAP,
    S_CALC,
    S_EMIT
  } state_t;

  state_t state;

  logic [bcg_pkg::PERIOD_W-1:0] cfg_period;
  logic [bcg_pkg::BEATS_W-1:0]  cfg_beats;
  logic [bcg_pkg::MEAS_W-1:0]   cfg_measures;

  logic [bcg_pkg::PERIOD_W-1:0] p_eff;
  logic [bcg_pkg::BEATS_W-1:0]  b_eff;
  logic [bcg_pkg::MEAS_W-1:0]   m_eff;

  logic [bcg_pkg::ACC_W-1:0]    acc;
  logic [bcg_pkg::SIXT_W-1:0]   sc;
  logic [bcg_pkg::EIGHTH_W-1:0] ec;
  logic [4:0]                   bc;
  logic [bcg_pkg::POS_W-1:0]    mp;
  logic                         playing;

  logic [bcg_pkg::ACC_W:0]      acc_sum;
  logic [bcg_pkg::ACC_W-1:0]    acc_sat;
  logic                         hit;
  logic [bcg_pkg::SIXT_W-1:0]   sc_inc;
  logic [bcg_pkg::EIGHTH_W-1:0] ec_inc;
  logic [4:0]                   bc_inc;
  logic                         even16;
  logic                         even8;
  logic                         wrap;

  logic [bcg_pkg::MEAS_W-1:0]     mod_rem;
  logic [bcg_pkg::MEAS_W-1:0]     mod_dvd;
  logic [bcg_pkg::MOD_CNT_W-1:0]  mod_cnt;
  logic [bcg_pkg::MEAS_W:0]       mod_try;
  logic [bcg_pkg::MEAS_W-1:0]     mod_next;

  bcg_pkg::bcg_event_t         ev_kind  [3];
  logic [bcg_pkg::INDEX_W-1:0] ev_index [3];
  logic [1:0]                  ev_count;
  logic [1:0]                  out_idx;

  logic [bcg_pkg::PROGRESS_BITS-1:0] progress;
  logic                              calc_start;
  bcg_pkg::bcg_operands_t            opnd;
  bcg_pkg::bcg_status_t              prog_status;

  logic s_accept;
  logic m_accept;

  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // effective register values
  assign p_eff = (cfg_period == '0) ? bcg_pkg::PERIOD_W'(1) : cfg_period;
  always_comb begin
    priority if (cfg_beats == '0) begin
      b_eff = bcg_pkg::BEATS_W'(1);
    end else if (cfg_beats > bcg_pkg::BEATS_W'(bcg_pkg::MAX_BEATS)) begin
      b_eff = bcg_pkg::BEATS_W'(bcg_pkg::MAX_BEATS);
    end else begin
      b_eff = cfg_beats;
    end
    priority if (cfg_measures == '0) begin
      m_eff = bcg_pkg::MEAS_W'(1);
    end else if (cfg_measures > bcg_pkg::MEAS_W'(bcg_pkg::MAX_MEASURES)) begin
      m_eff = bcg_pkg::MEAS_W'(bcg_pkg::MAX_MEASURES);
    end else begin
      m_eff = cfg_measures;
    end
  end

  assign acc_sum = {1'b0, acc} + (bcg_pkg::ACC_W + 1)'(s_tdata[bcg_pkg::TIME_BITS-1:0]);
  assign acc_sat = acc_sum[bcg_pkg::ACC_W] ? '1 : acc_sum[bcg_pkg::ACC_W-1:0];

  assign hit    = acc >= bcg_pkg::ACC_W'(p_eff);
  assign sc_inc = sc + 1'b1;
  assign ec_inc = ec + 1'b1;
  assign bc_inc = bc + 1'b1;
  assign even16 = !sc_inc[0];
  assign even8  = !ec_inc[0];
  assign wrap   = bc_inc >= b_eff;

  assign mod_try  = {mod_rem, mod_dvd[bcg_pkg::MEAS_W-1]};
  assign mod_next = (mod_try >= {1'b0, m_eff}) ? bcg_pkg::MEAS_W'(mod_try - {1'b0, m_eff})
                                               : mod_try[bcg_pkg::MEAS_W-1:0];

  assign opnd.period    = p_eff;
  assign opnd.beats     = b_eff;
  assign opnd.measures  = m_eff;
  assign opnd.sixteenth = sc;
  assign opnd.acc       = acc;
  assign opnd.measure   = mp;

  bcg_progress u_progress (
    .clk    (clk),
    .rst    (rst),
    .start  (calc_start),
    .opnd   (opnd),
    .status (prog_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cfg_period   <= bcg_pkg::PERIOD_RESET;
      cfg_beats    <= bcg_pkg::BEATS_RESET;
      cfg_measures <= bcg_pkg::MEAS_RESET;
      acc          <= '0;
      sc           <= '0;
      ec           <= '0;
      bc           <= '0;
      mp           <= '0;
      playing      <= 1'b0;
      calc_start   <= 1'b0;
      ev_count     <= 2'd1;
      out_idx      <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_addr)
          bcg_pkg::REG_PERIOD:   cfg_period   <= cfg_wdata;
          bcg_pkg::REG_BEATS:    cfg_beats    <= cfg_wdata[bcg_pkg::BEATS_W-1:0];
          bcg_pkg::REG_MEASURES: cfg_measures <= cfg_wdata[bcg_pkg::MEAS_W-1:0];
          default: ;
        endcase
      end

      calc_start <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            if (s_tuser[0]) begin
              acc         <= '0;
              sc          <= '0;
              ec          <= '0;
              bc          <= '0;
              mp          <= '0;
              playing     <= 1'b1;
              ev_kind[0]  <= bcg_pkg::EV_SIXTEENTH;
              ev_index[0] <= '0;
              ev_kind[1]  <= bcg_pkg::EV_EIGHTH;
              ev_index[1] <= '0;
              ev_kind[2]  <= bcg_pkg::EV_QUARTER;
              ev_index[2] <= '0;
              ev_count    <= 2'd3;
              calc_start  <= 1'b1;
              state       <= S_CALC;
            end else if (playing) begin
              acc   <= acc_sat;
              state <= S_STEP;
            end else begin
              ev_kind[0]  <= bcg_pkg::EV_NONE;
              ev_index[0] <= '0;
              ev_count    <= 2'd1;
              calc_start  <= 1'b1;
              state       <= S_CALC;
            end
          end
        end

        S_STEP: begin
          if (!hit) begin
            ev_kind[0]  <= bcg_pkg::EV_NONE;
            ev_index[0] <= '0;
            ev_count    <= 2'd1;
            calc_start  <= 1'b1;
            state       <= S_CALC;
          end else begin
            acc <= acc - bcg_pkg::ACC_W'(p_eff);
            sc  <= sc_inc;
            calc_start <= 1'b1;
            state      <= S_CALC;
            if (!even16) begin
              ev_kind[0]  <= bcg_pkg::EV_SIXTEENTH;
              ev_index[0] <= sc_inc;
              ev_count    <= 2'd1;
            end else if (!even8) begin
              ec          <= ec_inc;
              ev_kind[0]  <= bcg_pkg::EV_EIGHTH;
              ev_index[0] <= bcg_pkg::INDEX_W'(ec_inc);
              ev_kind[1]  <= bcg_pkg::EV_SIXTEENTH;
              ev_index[1] <= sc_inc;
              ev_count    <= 2'd2;
            end else begin
              ec          <= ec_inc;
              bc          <= bc_inc;
              ev_kind[0]  <= bcg_pkg::EV_EIGHTH;
              ev_index[0] <= bcg_pkg::INDEX_W'(ec_inc);
              ev_kind[1]  <= bcg_pkg::EV_QUARTER;
              ev_kind[2]  <= bcg_pkg::EV_SIXTEENTH;
              ev_count    <= 2'd3;
              if (wrap) begin
                sc          <= '0;
                ec          <= '0;
                bc          <= '0;
                ev_index[1] <= '0;
                ev_index[2] <= '0;
                mod_rem     <= '0;
                mod_dvd     <= {1'b0, mp} + 1'b1;
                mod_cnt     <= '0;
                calc_start  <= 1'b0;
                state       <= S_WRAP;
              end else begin
                ev_index[1] <= bcg_pkg::INDEX_W'(bc_inc);
                ev_index[2] <= sc_inc;
              end
            end
          end
        end

        // (measure + 1) mod measure count, one dividend bit a cycle
        S_WRAP: begin
          mod_rem <= mod_next;
          mod_dvd <= {mod_dvd[bcg_pkg::MEAS_W-2:0], 1'b0};
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == bcg_pkg::MOD_CNT_W'(bcg_pkg::MEAS_W - 1)) begin
            mp         <= mod_next[bcg_pkg::POS_W-1:0];
            calc_start <= 1'b1;
            state      <= S_CALC;
          end
        end

        S_CALC: begin
          if (prog_status.done) begin
            progress <= prog_status.progress;
            out_idx  <= '0;
            state    <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (m_tready) begin
            if (m_tlast) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 1'b1;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_EMIT);
  assign m_tuser  = ev_kind[out_idx];
  assign m_tlast  = (out_idx == ev_count - 2'd1);
  assign m_tdata  = {playing, progress, mp, ev_index[out_idx]};

`include "assert_macros.svh"

  `BCG_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input taken while results pending")
  `BCG_ASSERT_NEXT(a_no_early_result, s_accept, !m_tvalid, "result right after acceptance")
  `BCG_ASSERT_NEXT(a_last_frees_input, m_accept && m_tlast, s_tready, "input not freed after last")
  `BCG_ASSERT_NOW(a_none_is_single, m_tvalid && (m_tuser == bcg_pkg::EV_NONE), m_tlast,
                  "progress-only result not last")

endmodule

// File: rtl/core/bcg_progress.sv
// loop progress unit: shared multiplier builds the fraction, then it saturates or a serial restoring divide runs
`timescale 1ns / 1ps

module bcg_progress (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  bcg_pkg::bcg_operands_t opnd,
  output bcg_pkg::bcg_status_t  status
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_MUL_SC,
    P_MUL_PB,
    P_MUL_MP,
    P_MUL_DEN,
    P_CMP,
    P_DIV
  } pstate_t;

  pstate_t state;

  logic [bcg_pkg::MUL_A_W-1:0]       mul_a;
  logic [bcg_pkg::MUL_B_W-1:0]       mul_b;
  logic [bcg_pkg::NUM_W-1:0]         prod;
  logic [bcg_pkg::NUM_W-1:0]         num;
  logic [bcg_pkg::NUM_W-1:0]         den;
  logic [bcg_pkg::NUM_W-1:0]         rem;
  logic [bcg_pkg::NUM_W:0]           rem_shift;
  logic [bcg_pkg::MUL_A_W-1:0]       pb4;
  logic [bcg_pkg::PROGRESS_BITS-1:0] quo;
  logic [bcg_pkg::DIV_CNT_W-1:0]     cnt;
  logic                              done;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      P_MUL_SC: begin
        mul_a = bcg_pkg::MUL_A_W'(opnd.period);
        mul_b = bcg_pkg::MUL_B_W'(opnd.sixteenth);
      end
      P_MUL_PB: begin
        mul_a = bcg_pkg::MUL_A_W'(opnd.period);
        mul_b = bcg_pkg::MUL_B_W'(opnd.beats);
      end
      P_MUL_MP: begin
        mul_a = pb4;
        mul_b = bcg_pkg::MUL_B_W'(opnd.measure);
      end
      P_MUL_DEN: begin
        mul_a = pb4;
        mul_b = opnd.measures;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = bcg_pkg::NUM_W'(mul_a) * bcg_pkg::NUM_W'(mul_b);
  assign rem_shift = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (start) begin
            num   <= bcg_pkg::NUM_W'(opnd.acc);
            state <= P_MUL_SC;
          end
        end
        P_MUL_SC: begin
          num   <= num + prod;
          state <= P_MUL_PB;
        end
        P_MUL_PB: begin
          pb4   <= {prod[bcg_pkg::MUL_A_W-3:0], 2'b00};
          state <= P_MUL_MP;
        end
        P_MUL_MP: begin
          num   <= num + prod;
          state <= P_MUL_DEN;
        end
        P_MUL_DEN: begin
          den   <= prod;
          state <= P_CMP;
        end
        P_CMP: begin
          if (num >= den) begin
            quo   <= '1;
            done  <= 1'b1;
            state <= P_IDLE;
          end else begin
            rem   <= num;
            cnt   <= '0;
            state <= P_DIV;
          end
        end
        P_DIV: begin
          if (rem_shift >= {1'b0, den}) begin
            rem <= bcg_pkg::NUM_W'(rem_shift - {1'b0, den});
            quo <= {quo[bcg_pkg::PROGRESS_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_shift[bcg_pkg::NUM_W-1:0];
            quo <= {quo[bcg_pkg::PROGRESS_BITS-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == bcg_pkg::DIV_CNT_W'(bcg_pkg::PROGRESS_BITS - 1)) begin
            done  <= 1'b1;
            state <= P_IDLE;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  assign status.done     = done;
  assign status.progress = quo;

endmodule
